>>> rtl/plpc_pkg.sv
// Shared types and constants of the per-line pattern counter.
package plpc_pkg;

	// field widths
	localparam int TEXT_W   = 8;
	localparam int LINE_W   = 16;
	localparam int COUNT_W  = 12;
	localparam int PAT_W    = 64;
	localparam int PLEN_W   = 4;

	// configuration port
	localparam int APB_DW   = 64;
	localparam int APB_AW   = 4;

	// register indexes (8-byte stride, index is paddr[3])
	localparam logic REG_PATTERN_BYTES  = 1'b0;
	localparam logic REG_PATTERN_LENGTH = 1'b1;

	// defaults and limits
	localparam int                 MAX_PATTERN_BYTES_DEF = 8;
	localparam logic [TEXT_W-1:0]  NEWLINE_CODE          = 8'd10;
	localparam logic [LINE_W-1:0]  LINE_MAX              = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX             = '1;
	localparam logic [PLEN_W-1:0]  PLEN_RESET            = 4'd1;

	// result queue
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [TEXT_W-1:0] text_byte;
		logic              end_of_text;
	} text_word_t;

	typedef struct packed {
		logic [LINE_W-1:0]  line_number;
		logic [COUNT_W-1:0] match_count;
		logic               none_found;
		logic               is_closing;
	} result_word_t;

	typedef struct packed {
		logic [PAT_W-1:0]  pattern_bytes;
		logic [PLEN_W-1:0] pattern_length;
	} cfg_t;

	// results produced by one text word, first in order first
	typedef struct packed {
		logic [1:0]   num;
		result_word_t first;
		result_word_t second;
	} push_t;

endpackage

>>> rtl/plpc_stream_if.sv
// Valid/ready stream interface carrying one word of type T.
interface plpc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/per_line_pattern_counter.sv
// Top level: per-line pattern counter with APB configuration.
//
//   channel     dir  handshake        word
//   text_in     in   valid/ready      text_byte, end_of_text
//   result_out  out  valid/ready      line_number, match_count, none_found, is_closing
//   apb         in   psel/penable     pattern_bytes @0x0, pattern_length @0x8
//
// One text word per cycle while the input is not stalled; each word is held in the
// input register, and its zero to two results are written into a four-entry queue as it leaves that register.
// The input stalls only while the queue has fewer than two free entries.
// Reset clears the text state (line 1, empty window) and the queue;
// registers come up as pattern 0, length 1.
module per_line_pattern_counter #(
	parameter int MAX_PATTERN_BYTES = plpc_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	plpc_stream_if.sink                  text_in,
	plpc_stream_if.source                result_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [plpc_pkg::APB_AW-1:0]  paddr,
	input  logic [plpc_pkg::APB_DW-1:0]  pwdata,
	output logic [plpc_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import plpc_pkg::*;

	cfg_t              cfg;
	push_t             push;
	logic              room;
	logic [QCNT_W-1:0] level;

	plpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	plpc_core #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.text_in (text_in),
		.room    (room),
		.push    (push)
	);

	plpc_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.level      (level),
		.result_out (result_out)
	);

	// checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= QCNT_W'(QDEPTH))
		else $error("result queue overfilled");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> room)
		else $error("results pushed without room");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.data.is_closing |->
		result_out.data.match_count != '0 && !result_out.data.none_found)
		else $error("line result with zero count or none flag");

	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.data.is_closing |->
		result_out.data.match_count == '0)
		else $error("closing result with nonzero count");

endmodule

>>> rtl/plpc_cfg.sv
// APB register file holding the pattern and its length.
module plpc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [plpc_pkg::APB_AW-1:0]  paddr,
	input  logic [plpc_pkg::APB_DW-1:0]  pwdata,
	output logic [plpc_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output plpc_pkg::cfg_t               cfg
);
	import plpc_pkg::*;

	logic [PAT_W-1:0]  pattern_q;
	logic [PLEN_W-1:0] plen_q;
	logic              wr_en;
	logic              reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[APB_AW-1];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= PLEN_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PATTERN_BYTES:  pattern_q <= pwdata[PAT_W-1:0];
				REG_PATTERN_LENGTH: plen_q    <= pwdata[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			REG_PATTERN_BYTES:  prdata = APB_DW'(pattern_q);
			REG_PATTERN_LENGTH: prdata = APB_DW'(plen_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg.pattern_bytes  = pattern_q;
	assign cfg.pattern_length = plen_q;

endmodule

>>> rtl/plpc_core.sv
// Input register, window compare and line bookkeeping.
module plpc_core #(
	parameter int MAX_PATTERN_BYTES = plpc_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  plpc_pkg::cfg_t   cfg,
	plpc_stream_if.sink      text_in,
	input  logic             room,
	output plpc_pkg::push_t  push
);
	import plpc_pkg::*;

	localparam int WIN_W  = 8 * MAX_PATTERN_BYTES;
	localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

	// input register
	logic              valid_s1;
	logic [TEXT_W-1:0] byte_s1;
	logic              eot_s1;

	// text state
	logic [WIN_W-1:0]   window_q;
	logic [FILL_W-1:0]  fill_q;
	logic [LINE_W-1:0]  line_q;
	logic [COUNT_W-1:0] count_q;
	logic               any_q;

	logic               take;
	logic               adv;
	logic               is_nl;
	logic [WIN_W+7:0]   win_cat;
	logic [WIN_W-1:0]   win_n;
	logic [FILL_W-1:0]  fill_n;
	logic [PLEN_W-1:0]  eff_len;
	logic               hit;
	logic               all_eq;
	logic [COUNT_W-1:0] count_n;
	logic [LINE_W-1:0]  line_after;
	logic               any_n;
	logic [COUNT_W-1:0] line_cnt;
	logic               line_res;
	result_word_t       line_word;
	result_word_t       close_word;

	assign adv           = valid_s1 & room;
	assign text_in.ready = ~valid_s1 | room;
	assign take          = text_in.valid & text_in.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= text_in.data.text_byte;
			eot_s1  <= text_in.data.end_of_text;
		end
	end

	// shifted window and fill
	assign is_nl   = (byte_s1 == NEWLINE_CODE);
	assign win_cat = {window_q, byte_s1};
	assign win_n   = win_cat[WIN_W-1:0];
	assign fill_n  = (fill_q == FILL_W'(MAX_PATTERN_BYTES)) ? fill_q : fill_q + 1'b1;
	assign eff_len = (cfg.pattern_length > PLEN_W'(MAX_PATTERN_BYTES)) ?
		PLEN_W'(MAX_PATTERN_BYTES) : cfg.pattern_length;

	// compare newest bytes with the pattern, one candidate per length
	always_comb begin
		hit    = 1'b0;
		all_eq = 1'b0;
		for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
			all_eq = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (win_n[8*k +: 8] != cfg.pattern_bytes[8*(l-1-k) +: 8])
					all_eq = 1'b0;
			end
			if ((eff_len == PLEN_W'(l)) && (int'(fill_n) >= l) && all_eq)
				hit = 1'b1;
		end
	end

	// counters
	assign count_n    = (!is_nl && hit && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign line_after = (is_nl && line_q != LINE_MAX) ? line_q + 1'b1 : line_q;
	assign any_n      = any_q | (~is_nl & hit);

	// result words
	assign line_cnt = is_nl ? count_q : count_n;
	assign line_res = (line_cnt != '0) && (is_nl || eot_s1);

	assign line_word.line_number  = line_q;
	assign line_word.match_count  = line_cnt;
	assign line_word.none_found   = 1'b0;
	assign line_word.is_closing   = 1'b0;

	assign close_word.line_number = line_after;
	assign close_word.match_count = '0;
	assign close_word.none_found  = ~any_n;
	assign close_word.is_closing  = 1'b1;

	always_comb begin
		push.num    = 2'd0;
		push.first  = line_res ? line_word : close_word;
		push.second = close_word;
		if (adv)
			push.num = 2'({1'b0, line_res} + {1'b0, eot_s1});
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			line_q   <= LINE_W'(1);
			count_q  <= '0;
			any_q    <= 1'b0;
		end else if (adv) begin
			if (eot_s1) begin
				window_q <= '0;
				fill_q   <= '0;
				line_q   <= LINE_W'(1);
				count_q  <= '0;
				any_q    <= 1'b0;
			end else if (is_nl) begin
				window_q <= '0;
				fill_q   <= '0;
				line_q   <= line_after;
				count_q  <= '0;
			end else begin
				window_q <= win_n;
				fill_q   <= fill_n;
				count_q  <= count_n;
				any_q    <= any_n;
			end
		end
	end

endmodule

>>> rtl/plpc_outq.sv
// Small result queue taking up to two words per cycle, giving one while the reader is ready.
module plpc_outq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  plpc_pkg::push_t           push,
	output logic                      room,
	output logic [plpc_pkg::QCNT_W-1:0] level,
	plpc_stream_if.source             result_out
);
	import plpc_pkg::*;

	result_word_t      mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;
	logic [QPTR_W-1:0] wr_p1;

	assign pop   = result_out.valid & result_out.ready;
	assign wr_p1 = wr_q + 1'b1;
	assign room  = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign level = cnt_q;

	assign result_out.valid = (cnt_q != '0);
	assign result_out.data  = mem[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0)
			mem[wr_q] <= push.first;
		if (push.num == 2'd2)
			mem[wr_p1] <= push.second;
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.num);
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(push.num) - QCNT_W'(pop);
		end
	end

endmodule
